// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL, included by the top-level operator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/cpmo_pkg.sv =====
// Types, codes and arithmetic helpers of the cutting-plane matrix operator.
`default_nettype none
package cpmo_pkg;

  localparam int NODE_W = 6;
  localparam int VAL_W  = 64;
  localparam int ACC_W  = 70;   // exact sum of up to 21 signed 64-bit entries

  // Opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CUT    = 2'd2;
  localparam logic [1:0] OP_UPDATE = 2'd3;

  // Cut sizes
  localparam logic [1:0] SZ_TRI  = 2'd0;
  localparam logic [1:0] SZ_PENT = 2'd1;
  localparam logic [1:0] SZ_HEPT = 2'd2;

  // Configuration register
  localparam logic       REG_ACTIVE_NODES = 1'b0;
  localparam logic [6:0] ACTIVE_NODES_RST = 7'd64;

  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        cut_size;
    logic [2:0]        cut_type;
    logic [5:0]        node0;
    logic [5:0]        node1;
    logic [5:0]        node2;
    logic [5:0]        node3;
    logic [5:0]        node4;
    logic [5:0]        node5;
    logic [5:0]        node6;
    logic signed [63:0] value_in;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               index_error;
    logic               overflow;
  } rsp_t;

  typedef struct packed {
    logic [6:0] mask;     // negated nodes
    logic       upd_ok;   // update does something
  } sign_t;

  typedef struct packed {
    logic        ovf;
    logic [63:0] value;
  } sat_t;

  // Sign vector of a cut; size is already clamped to heptagon
  function automatic sign_t neg_mask(input logic [1:0] size, input logic [2:0] ctype);
    sign_t r;
    r.upd_ok = 1'b1;
    r.mask   = 7'd0;
    case (size)
      SZ_TRI: begin
        case (ctype)
          3'd1:    r.mask = 7'd0;
          3'd2:    r.mask = 7'd4;
          3'd3:    r.mask = 7'd2;
          default: r.mask = 7'd1;
        endcase
      end
      SZ_PENT: begin
        case (ctype)
          3'd1:    r.mask = 7'd0;
          3'd2:    r.mask = 7'd1;
          3'd3:    r.mask = 7'd3;
          default: begin r.mask = 7'd3; r.upd_ok = 1'b0; end
        endcase
      end
      default: begin
        case (ctype)
          3'd1:    r.mask = 7'd0;
          3'd2:    r.mask = 7'd1;
          3'd3:    r.mask = 7'd3;
          3'd4:    r.mask = 7'd7;
          default: begin r.mask = 7'd7; r.upd_ok = 1'b0; end
        endcase
      end
    endcase
    return r;
  endfunction

  // Add a signed magnitude to a two's complement value, saturating
  function automatic sat_t sat_add(input logic [63:0] base, input logic neg,
                                   input logic [63:0] mag);
    logic [65:0] b;
    logic [65:0] mg;
    logic [65:0] t;
    sat_t        r;
    b = {{2{base[63]}}, base};
    mg = {2'b00, mag};
    t = neg ? (b - mg) : (b + mg);
    if (t[65:63] == 3'b000 || t[65:63] == 3'b111) begin
      r.ovf   = 1'b0;
      r.value = t[63:0];
    end else begin
      r.ovf   = 1'b1;
      r.value = t[65] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cpmo_mem.sv =====
// Matrix store: one write port, one read port, registered read data.
`default_nettype none
module cpmo_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [63:0]        rdata
);

  logic [63:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/cpmo_div3.sv =====
// Divide by three, sixteen quotient bits per cycle by reciprocal multiplication.
`default_nettype none
module cpmo_div3 (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [cpmo_pkg::ACC_W-1:0] num,
  output logic                           done,
  output logic [cpmo_pkg::ACC_W-1:0]      quot
);
  import cpmo_pkg::*;

  localparam int DIG  = 16;
  localparam int NDIG = (ACC_W + DIG - 1) / DIG;
  localparam int SW   = NDIG * DIG;
  localparam int CW   = $clog2(NDIG + 1);
  // ceil(2^19 / 3): exact floor(x / 3) for every x below 2^19
  localparam logic [17:0] RECIP = 18'd174763;

  logic [CW-1:0]  cnt;
  logic           running;
  logic [SW-1:0]  sh;
  logic [1:0]     rem;
  logic [DIG+1:0] x;
  logic [35:0]    prod;
  logic [DIG-1:0] qd;
  logic [DIG+1:0] rx;

  // next quotient digit: carried remainder on top of the next 16 numerator bits
  assign x    = {rem, sh[SW-1 -: DIG]};
  assign prod = {18'd0, x} * {18'd0, RECIP};
  assign qd   = prod[19 +: DIG];
  assign rx   = x - ({2'b00, qd} + {1'b0, qd, 1'b0});
  assign quot = sh[ACC_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(NDIG);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // numerator digits shift out on top, quotient digits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= {{(SW-ACC_W){1'b0}}, num};
      rem <= 2'd0;
    end else if (running) begin
      sh  <= {sh[SW-DIG-1:0], qd};
      rem <= rx[1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cutting_plane_matrix_operator.sv =====
// Cutting-plane matrix operator: control, address walker and arithmetic.
//
//  channel   signals                                  direction
//  request   start, busy, req                         in  (start & !busy)
//  result    done, rsp                                out (one-cycle strobe)
//  config    psel penable pwrite paddr pwdata prdata  APB, pready tied high
//
// Write, index error or void update: answered from idle. Read: through S_RD.
// Cut operator: one memory read per node pair (3, 10 or 21), then drain and sum,
// and for a heptagon a pass through the divide-by-three unit.
// Cut update: read-modify-write of every entry through the memory
// (6, 20 or 42 entries), after a divide-by-three for a heptagon.
// Reset clears control only; the matrix store is undefined until written.
// busy is high while an item is in work; results cannot be stalled.
`default_nettype none
module cutting_plane_matrix_operator #(
  parameter int MAX_NODES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire cpmo_pkg::req_t req,
  output logic                busy,
  output logic                done,
  output cpmo_pkg::rsp_t      rsp,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [0:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cpmo_pkg::*;

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = AW + 7;
  localparam int LW    = ($clog2(MAX_NODES + 1) > 7) ? $clog2(MAX_NODES + 1) : 7;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_GATH  = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_OSUM  = 4'd4;
  localparam logic [3:0] S_ODIV  = 4'd5;
  localparam logic [3:0] S_UDIV  = 4'd6;
  localparam logic [3:0] S_URD   = 4'd7;
  localparam logic [3:0] S_UWR   = 4'd8;

  function automatic logic [AW-1:0] eaddr(input logic [5:0] r, input logic [5:0] s);
    logic [MW-1:0] full;
    full = MW'(r) * MW'(MAX_NODES) + MW'(s);
    return full[AW-1:0];
  endfunction

  logic [3:0]  state;
  logic [6:0]  active_nodes;

  // request registers
  logic [1:0]  size;
  logic [2:0]  used;
  logic [6:0]  omask;
  logic [5:0]  onode [7];
  logic [63:0] v;

  // pair walker
  logic [5:0]  n [7];
  logic [5:0]  bl [6];
  logic [6:0]  m;
  logic [5:0]  bm;
  logic [2:0]  rem;
  logic [2:0]  bcnt;
  logic        pass;
  logic        last;

  // datapath
  logic signed [ACC_W-1:0] acc;
  logic        gv;
  logic        tn_d;
  logic [63:0] inc;
  logic [AW-1:0] waddr;
  logic        sn;
  logic        ovf;

  // memory and divider
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   rdata;
  logic          div_start;
  logic [ACC_W-1:0] div_num;
  logic          div_done;
  logic [ACC_W-1:0] div_quot;

  // accept-time decode
  logic        accept;
  logic [5:0]  in_nodes [7];
  logic [1:0]  in_size;
  logic [2:0]  in_used;
  sign_t       in_sign;
  logic [LW-1:0] limit;
  logic        bad;
  logic [63:0] mv;
  logic [64:0] mv_r;
  logic        load;
  logic [5:0]  src [7];
  logic [6:0]  src_mask;
  logic [2:0]  src_used;

  // operator finish
  logic              neg_s;
  logic [ACC_W-1:0]  mag_s;
  logic [ACC_W-1:0]  num_s;
  logic [ACC_W-1:0]  q_fin;
  sat_t              fin;
  logic [63:0]       fin_val;
  logic              fin_ovf;
  sat_t              upd;
  logic signed [ACC_W-1:0] term;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign last   = (rem == 3'd2);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ACTIVE_NODES) ? {25'd0, active_nodes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_nodes <= ACTIVE_NODES_RST;
    end else if (psel && penable && pwrite && pready && paddr == REG_ACTIVE_NODES) begin
      active_nodes <= pwdata[6:0];
    end
  end

  // decode of the incoming request
  always_comb begin
    in_nodes[0] = req.node0;
    in_nodes[1] = req.node1;
    in_nodes[2] = req.node2;
    in_nodes[3] = req.node3;
    in_nodes[4] = req.node4;
    in_nodes[5] = req.node5;
    in_nodes[6] = req.node6;
    in_size = (req.cut_size > SZ_HEPT) ? SZ_HEPT : req.cut_size;
    if (req.opcode == OP_WRITE || req.opcode == OP_READ) begin
      in_used = 3'd2;
    end else begin
      case (in_size)
        SZ_TRI:  in_used = 3'd3;
        SZ_PENT: in_used = 3'd5;
        default: in_used = 3'd7;
      endcase
    end
    in_sign = neg_mask(in_size, req.cut_type);
    limit = (LW'(active_nodes) < LW'(MAX_NODES)) ? LW'(active_nodes) : LW'(MAX_NODES);
    bad = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (3'(i) < in_used && LW'(in_nodes[i]) >= limit) begin
        bad = 1'b1;
      end
    end
    mv = req.value_in[63] ? (~req.value_in + 64'd1) : req.value_in;
    case (in_size)
      SZ_TRI:  mv_r = (65'(mv) + 65'd1) >> 1;
      SZ_PENT: mv_r = (65'(mv) + 65'd2) >> 2;
      default: mv_r = (65'(mv) + 65'd3) >> 1;
    endcase
  end

  // walker load source: request at accept, saved copy for the second pass
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      src[i] = (state == S_IDLE) ? in_nodes[i] : onode[i];
    end
    src_mask = (state == S_IDLE) ? in_sign.mask : omask;
    src_used = (state == S_IDLE) ? in_used : used;
    load = (accept && !bad && (req.opcode == OP_CUT || req.opcode == OP_UPDATE))
        || (state == S_UWR && last && !pass);
  end

  // pair walker: n[0] is node a, bl[0] node b
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 7; i++) n[i] <= src[i];
      for (int i = 0; i < 6; i++) bl[i] <= src[i+1];
      m    <= src_mask;
      bm   <= src_mask[6:1];
      rem  <= src_used;
      bcnt <= src_used - 3'd1;
    end else if (state == S_GATH || state == S_UWR) begin
      if (bcnt > 3'd1) begin
        for (int i = 0; i < 5; i++) bl[i] <= bl[i+1];
        bm   <= bm >> 1;
        bcnt <= bcnt - 3'd1;
      end else begin
        for (int i = 0; i < 6; i++) n[i] <= n[i+1];
        for (int i = 0; i < 5; i++) bl[i] <= n[i+2];
        m    <= m >> 1;
        bm   <= {1'b0, m[6:2]};
        rem  <= rem - 3'd1;
        bcnt <= rem - 3'd2;
      end
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = waddr;
    mem_wdata = upd.value;
    if (state == S_IDLE) begin
      mem_we    = accept && !bad && req.opcode == OP_WRITE;
      mem_waddr = eaddr(req.node0, req.node1);
      mem_wdata = req.value_in;
    end else if (state == S_UWR) begin
      mem_we = 1'b1;
    end
    if (state == S_IDLE) begin
      mem_raddr = eaddr(req.node0, req.node1);
    end else if (state == S_URD && pass) begin
      mem_raddr = eaddr(bl[0], n[0]);
    end else begin
      mem_raddr = eaddr(n[0], bl[0]);
    end
  end

  cpmo_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // operator arithmetic
  always_comb begin
    term  = tn_d ? -{{6{rdata[63]}}, rdata} : {{6{rdata[63]}}, rdata};
    neg_s = acc[ACC_W-1];
    mag_s = neg_s ? ACC_W'(-acc) : ACC_W'(acc);
    num_s = mag_s + ((size != SZ_TRI) ? ACC_W'(1) : ACC_W'(0));
    if (state == S_ODIV) begin
      q_fin = div_quot;
    end else if (size == SZ_PENT) begin
      q_fin = num_s >> 1;
    end else begin
      q_fin = num_s;
    end
    fin = sat_add(v, neg_s, q_fin[63:0]);
    if (|q_fin[ACC_W-1:64]) begin
      fin_ovf = 1'b1;
      fin_val = neg_s ? VAL_MIN : VAL_MAX;
    end else begin
      fin_ovf = fin.ovf;
      fin_val = fin.value;
    end
    upd = sat_add(rdata, sn, inc);
    div_start = (state == S_OSUM && size == SZ_HEPT)
             || (accept && !bad && req.opcode == OP_UPDATE && in_sign.upd_ok
                 && in_size == SZ_HEPT);
    div_num = (state == S_IDLE) ? ACC_W'(mv_r) : num_s;
  end

  cpmo_div3 u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot)
  );

  // gather accumulation, one entry per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= '0;
    end else if (gv) begin
      acc <= acc + term;
    end
    tn_d <= m[0] ^ bm[0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      gv    <= 1'b0;
    end else begin
      done <= 1'b0;
      gv   <= (state == S_GATH);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (bad || req.opcode == OP_WRITE
                || (req.opcode == OP_UPDATE && !in_sign.upd_ok)) begin
              done <= 1'b1;
            end else if (req.opcode == OP_READ) begin
              state <= S_RD;
            end else if (req.opcode == OP_CUT) begin
              state <= S_GATH;
            end else if (in_size == SZ_HEPT) begin
              state <= S_UDIV;
            end else begin
              state <= S_URD;
            end
          end
        end
        S_RD: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_GATH: begin
          if (last && bcnt == 3'd1) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_OSUM;
        S_OSUM: begin
          if (size == SZ_HEPT) begin
            state <= S_ODIV;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_ODIV: begin
          if (div_done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_UDIV: begin
          if (div_done) state <= S_URD;
        end
        S_URD: state <= S_UWR;
        S_UWR: begin
          if (last && pass) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_URD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      size  <= in_size;
      used  <= in_used;
      omask <= in_sign.mask;
      for (int i = 0; i < 7; i++) onode[i] <= in_nodes[i];
      v     <= req.value_in;
      ovf   <= 1'b0;
      pass  <= 1'b0;
      inc   <= mv_r[63:0];
      rsp.result_value <= '0;
      rsp.index_error  <= bad;
      rsp.overflow     <= 1'b0;
    end else begin
      unique case (state)
        S_RD: rsp.result_value <= rdata;
        S_OSUM, S_ODIV: begin
          rsp.result_value <= fin_val;
          rsp.overflow     <= fin_ovf;
        end
        S_UDIV: begin
          if (div_done) inc <= div_quot[63:0];
        end
        S_URD: begin
          waddr <= mem_raddr;
          sn    <= v[63] ^ m[0] ^ bm[0];
        end
        S_UWR: begin
          ovf <= ovf | upd.ovf;
          rsp.overflow <= ovf | upd.ovf;
          if (last && !pass) pass <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_IMP(a_done_idle, done, !busy)
  `ASSERT_IMP(a_err_clean, done && rsp.index_error, rsp.result_value == 64'd0 && !rsp.overflow)
  `ASSERT_IMP(a_we_state, mem_we, state == S_IDLE || state == S_UWR)
  `ASSERT_NXT(a_div_exit, (state == S_ODIV || state == S_UDIV) && div_done, state != S_ODIV && state != S_UDIV)

endmodule
`default_nettype wire

// ===== tb/tb_cutting_plane_matrix_operator.sv =====
// Testbench for the cutting-plane matrix operator: random and directed requests, checked
// against a predictor of the matrix store.
`default_nettype none
module tb_cutting_plane_matrix_operator;
  import cpmo_pkg::*;

  // in-range random nodes stay below this, so every entry they touch is written first
  localparam int unsigned FILL_NODES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  req_t        req = '0;
  logic        busy;
  logic        done;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cutting_plane_matrix_operator u_top (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic [63:0] mat_model [0:4095];
  logic [6:0]  node_limit_reg = ACTIVE_NODES_RST;
  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  int unsigned idle_pct = 0;
  int unsigned fails = 0;

  // Saturating signed add of a magnitude; returns {overflow, value}
  function automatic logic [64:0] sat_sum(logic [63:0] base, logic neg, logic [63:0] mag);
    logic signed [65:0] t;
    t = $signed({{2{base[63]}}, base});
    if (neg) t = t - $signed({2'b00, mag});
    else t = t + $signed({2'b00, mag});
    if (t > $signed({2'b00, VAL_MAX})) return {1'b1, VAL_MAX};
    if (t < -$signed({2'b00, VAL_MIN})) return {1'b1, VAL_MIN};
    return {1'b0, t[63:0]};
  endfunction

  // Expected response of one request; applies writes and updates to the model store
  function automatic rsp_t apply_request(req_t r);
    logic [5:0]          nd [7];
    logic [1:0]          sz;
    int unsigned         used;
    int unsigned         lim;
    logic [6:0]          neg;
    logic                upd_ok;
    logic signed [71:0]  acc;
    logic [71:0]         mag;
    logic [71:0]         quo;
    logic [63:0]         x;
    logic [63:0]         vmag;
    logic [63:0]         inc;
    logic [64:0]         s;
    logic [11:0]         ix;
    int unsigned         dv;
    rsp_t                o;
    nd[0] = r.node0; nd[1] = r.node1; nd[2] = r.node2; nd[3] = r.node3;
    nd[4] = r.node4; nd[5] = r.node5; nd[6] = r.node6;
    o = '0;
    lim = (node_limit_reg < 64) ? node_limit_reg : 64;
    sz = (r.cut_size == 2'd3) ? SZ_HEPT : r.cut_size;
    used = (r.opcode == OP_WRITE || r.opcode == OP_READ) ? 2 :
           (sz == SZ_TRI) ? 3 : (sz == SZ_PENT) ? 5 : 7;
    for (int a = 0; a < used; a++) if (nd[a] >= lim) o.index_error = 1'b1;
    if (o.index_error) return o;
    // sign vector: set bits are negated nodes
    upd_ok = 1'b1;
    if (sz == SZ_TRI) begin
      case (r.cut_type)
        3'd1: neg = 7'd0;
        3'd2: neg = 7'd4;
        3'd3: neg = 7'd2;
        default: neg = 7'd1;
      endcase
    end else begin
      case (r.cut_type)
        3'd1: neg = 7'd0;
        3'd2: neg = 7'd1;
        3'd3: neg = 7'd3;
        3'd4: neg = (sz == SZ_PENT) ? 7'd3 : 7'd7;
        default: neg = (sz == SZ_PENT) ? 7'd3 : 7'd7;
      endcase
      if (r.cut_type < 1 || r.cut_type > ((sz == SZ_PENT) ? 3 : 4)) upd_ok = 1'b0;
    end
    case (r.opcode)
      OP_WRITE: mat_model[{nd[0], nd[1]}] = r.value_in;
      OP_READ:  o.result_value = mat_model[{nd[0], nd[1]}];
      OP_CUT: begin
        acc = '0;
        for (int a = 0; a < used; a++)
          for (int b = a + 1; b < used; b++) begin
            x = mat_model[{nd[a], nd[b]}];
            if (neg[a] ^ neg[b]) acc = acc - $signed({{8{x[63]}}, x});
            else acc = acc + $signed({{8{x[63]}}, x});
          end
        dv = sz + 1;
        mag = (acc < 0) ? -acc : acc;
        quo = (mag + dv / 2) / dv;
        if (quo[71:64] != 0) begin
          o.overflow = 1'b1;
          o.result_value = (acc < 0) ? VAL_MIN : VAL_MAX;
        end else begin
          s = sat_sum(r.value_in, acc < 0, quo[63:0]);
          o.overflow = s[64];
          o.result_value = s[63:0];
        end
      end
      default: begin
        if (upd_ok) begin
          dv = (sz == SZ_TRI) ? 2 : (sz == SZ_PENT) ? 4 : 6;
          vmag = r.value_in[63] ? -r.value_in : r.value_in;
          inc = 64'(({1'b0, vmag} + dv / 2) / dv);
          for (int pass = 0; pass < 2; pass++)
            for (int a = 0; a < used; a++)
              for (int b = a + 1; b < used; b++) begin
                ix = (pass == 0) ? {nd[a], nd[b]} : {nd[b], nd[a]};
                s = sat_sum(mat_model[ix], r.value_in[63] ^ neg[a] ^ neg[b], inc);
                mat_model[ix] = s[63:0];
                if (s[64]) o.overflow = 1'b1;
              end
        end
      end
    endcase
    return o;
  endfunction

  // Driver: offers queued requests, holds each until accepted
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_rsps.push_back(apply_request(req));
      if (!(start && busy)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          req <= pending_reqs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result strobe with the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result %h", rsp);
        fails++;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp.result_value !== e.result_value) begin
          $error("result_value expected %h actual %h", e.result_value, rsp.result_value);
          fails++;
        end
        if (rsp.index_error !== e.index_error) begin
          $error("index_error expected %b actual %b", e.index_error, rsp.index_error);
          fails++;
        end
        if (rsp.overflow !== e.overflow) begin
          $error("overflow expected %b actual %b", e.overflow, rsp.overflow);
          fails++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return {$urandom, $urandom};
      default: return {28'd0, 4'($urandom_range(15)), $urandom} ^
                      ($urandom_range(1) ? 64'hFFFF_FFFF_0000_0000 : 64'd0);
    endcase
  endfunction

  // In-range nodes come from the filled corner; out-of-range ones from at or above the limit
  function automatic logic [5:0] rand_node(int unsigned lim);
    int unsigned hi;
    hi = (lim < FILL_NODES) ? lim : FILL_NODES;
    if (lim < 64 && (hi == 0 || $urandom_range(15) == 0)) return 6'($urandom_range(63, lim));
    return 6'($urandom_range(hi - 1));
  endfunction

  function automatic req_t mk_req(logic [1:0] op, logic [1:0] sz, logic [2:0] ty,
                                  logic [5:0] n0, logic [5:0] n1, logic [5:0] n2,
                                  logic [63:0] v);
    req_t r;
    r = '{opcode: op, cut_size: sz, cut_type: ty, node0: n0, node1: n1, node2: n2,
          node3: 6'd3, node4: 6'd4, node5: 6'd5, node6: 6'd6, value_in: v};
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t        r;
    int unsigned lim;
    int unsigned k;
    lim = (node_limit_reg < 64) ? node_limit_reg : 64;
    k = $urandom_range(99);
    r.opcode = (k < 15) ? OP_WRITE : (k < 30) ? OP_READ : (k < 70) ? OP_CUT : OP_UPDATE;
    r.cut_size = 2'($urandom_range(3));
    r.cut_type = ($urandom_range(99) < 85) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7));
    r.node0 = rand_node(lim); r.node1 = rand_node(lim); r.node2 = rand_node(lim);
    r.node3 = rand_node(lim); r.node4 = rand_node(lim); r.node5 = rand_node(lim);
    r.node6 = rand_node(lim);
    if ($urandom_range(9) == 0) r.node1 = r.node0;
    r.value_in = rand_value();
    return r;
  endfunction

  // Register write over the APB port; block must be idle
  task automatic write_active_nodes(logic [6:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= REG_ACTIVE_NODES;
    pwdata <= {25'($urandom_range(32'h1FF_FFFF)), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    node_limit_reg = val;
  endtask

  // Wait until every request is accepted and answered, then let the block settle
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || start || busy)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic run_phase(logic [6:0] lim, int unsigned n, int unsigned idle);
    write_active_nodes(lim);
    idle_pct = idle;
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
    drain();
  endtask

  // Stimulus sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // every entry among the low nodes gets written before anything reads it
    for (int r = 0; r < FILL_NODES; r++)
      for (int c = 0; c < FILL_NODES; c++)
        pending_reqs.push_back(mk_req(OP_WRITE, SZ_TRI, 3'd1, r[5:0], c[5:0], 6'd0,
                                      rand_value()));
    drain();
    // directed: extremes, every operation, sizes and sign types
    pending_reqs.push_back(mk_req(OP_WRITE, SZ_TRI, 3'd1, 6'd63, 6'd63, 6'd0, VAL_MAX));
    pending_reqs.push_back(mk_req(OP_READ, SZ_TRI, 3'd1, 6'd63, 6'd63, 6'd0, 64'd0));
    pending_reqs.push_back(mk_req(OP_WRITE, SZ_TRI, 3'd1, 6'd1, 6'd2, 6'd0, VAL_MIN));
    pending_reqs.push_back(mk_req(OP_READ, SZ_TRI, 3'd1, 6'd1, 6'd2, 6'd0, 64'd0));
    pending_reqs.push_back(mk_req(OP_WRITE, SZ_TRI, 3'd1, 6'd0, 6'd1, 6'd0, VAL_MAX));
    pending_reqs.push_back(mk_req(OP_WRITE, SZ_TRI, 3'd1, 6'd0, 6'd2, 6'd0, VAL_MAX));
    pending_reqs.push_back(mk_req(OP_CUT, SZ_TRI, 3'd1, 6'd0, 6'd1, 6'd2, VAL_MAX));
    pending_reqs.push_back(mk_req(OP_WRITE, SZ_TRI, 3'd1, 6'd1, 6'd2, 6'd0, VAL_MAX));
    for (int t = 0; t < 8; t++)
      pending_reqs.push_back(mk_req(OP_CUT, SZ_TRI, t[2:0], 6'd0, 6'd1, 6'd2, VAL_MIN));
    pending_reqs.push_back(mk_req(OP_CUT, SZ_PENT, 3'd5, 6'd0, 6'd1, 6'd2, 64'd1));
    pending_reqs.push_back(mk_req(OP_CUT, 2'd3, 3'd4, 6'd0, 6'd1, 6'd2, 64'd7));
    pending_reqs.push_back(mk_req(OP_CUT, SZ_HEPT, 3'd0, 6'd5, 6'd5, 6'd5, 64'd3));
    pending_reqs.push_back(mk_req(OP_UPDATE, SZ_TRI, 3'd2, 6'd0, 6'd1, 6'd2, VAL_MIN));
    pending_reqs.push_back(mk_req(OP_UPDATE, SZ_PENT, 3'd7, 6'd0, 6'd1, 6'd2, VAL_MAX));
    pending_reqs.push_back(mk_req(OP_UPDATE, SZ_HEPT, 3'd4, 6'd9, 6'd9, 6'd2, VAL_MAX));
    pending_reqs.push_back(mk_req(OP_UPDATE, 2'd3, 3'd1, 6'd0, 6'd1, 6'd2, 64'hFFFF_FFFF_FFFF_FFFD));
    pending_reqs.push_back(mk_req(OP_READ, SZ_TRI, 3'd1, 6'd0, 6'd1, 6'd0, 64'd0));
    drain();
    // random phases across limits and sender idling
    run_phase(7'd64, 220, 0);
    run_phase(7'd7, 160, 69);
    run_phase(7'd1, 90, 37);
    run_phase(7'd0, 30, 0);
    run_phase(7'd127, 220, 37);
    run_phase(7'd65, 180, 69);
    run_phase(7'd40, 180, 0);
    run_phase(7'd64, 150, 37);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/cpmo_pkg.sv
rtl/cpmo_mem.sv
rtl/cpmo_div3.sv
rtl/cutting_plane_matrix_operator.sv
tb/tb_cutting_plane_matrix_operator.sv
